// ===== design/stl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the symbol table lookup block.
// Used by the register file, the parser and the top level; no dependencies.
package stl_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned KeyLenW  = 6;
  localparam int unsigned KeyBytes = 32;
  localparam int unsigned KeyW     = KeyBytes * ByteW;
  localparam int unsigned AddrW    = 16;
  localparam int unsigned CntW     = 8;
  localparam int unsigned DataW    = 64;
  localparam int unsigned PaddrW   = 6;
  localparam int unsigned RegIdxW  = 3;

  // Longest key that can match any entry.
  localparam logic [KeyLenW-1:0] MaxKey = 6'd32;

  localparam logic [ByteW-1:0] MagicS = 8'h53;
  localparam logic [ByteW-1:0] MagicY = 8'h59;
  localparam logic [ByteW-1:0] MagicM = 8'h4D;

  // Register indexes on the configuration port.
  localparam logic [RegIdxW-1:0] RegKeyLength  = 3'd0;
  localparam logic [RegIdxW-1:0] RegKeyLow     = 3'd1;
  localparam logic [RegIdxW-1:0] RegKeyMidLow  = 3'd2;
  localparam logic [RegIdxW-1:0] RegKeyMidHigh = 3'd3;
  localparam logic [RegIdxW-1:0] RegKeyHigh    = 3'd4;

  typedef enum logic [2:0] {
    PhHeader = 3'd0,
    PhSize   = 3'd1,
    PhLen    = 3'd2,
    PhName   = 3'd3,
    PhAddr   = 3'd4,
    PhDone   = 3'd5
  } phase_e;

  typedef struct packed {
    logic [KeyLenW-1:0] key_length;
    logic [KeyW-1:0]    key_bytes;
  } key_cfg_t;

  typedef struct packed {
    phase_e phase;
  } stl_status_t;

endpackage

// ===== design/stl_cfg_regs.sv =====
`timescale 1ns / 1ps
// APB-style register file holding the search key.
// Depends on stl_pkg.
module stl_cfg_regs
  import stl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  output key_cfg_t          key_cfg_o
);

  logic [KeyLenW-1:0] key_length_q;
  logic [DataW-1:0]   key_low_q, key_mid_low_q, key_mid_high_q, key_high_q;
  logic [RegIdxW-1:0] reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PaddrW-1:PaddrW-RegIdxW];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q   <= '0;
      key_low_q      <= '0;
      key_mid_low_q  <= '0;
      key_mid_high_q <= '0;
      key_high_q     <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegKeyLength:  key_length_q   <= pwdata[KeyLenW-1:0];
        RegKeyLow:     key_low_q      <= pwdata;
        RegKeyMidLow:  key_mid_low_q  <= pwdata;
        RegKeyMidHigh: key_mid_high_q <= pwdata;
        RegKeyHigh:    key_high_q     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegKeyLength:  prdata = {{(DataW-KeyLenW){1'b0}}, key_length_q};
      RegKeyLow:     prdata = key_low_q;
      RegKeyMidLow:  prdata = key_mid_low_q;
      RegKeyMidHigh: prdata = key_mid_high_q;
      RegKeyHigh:    prdata = key_high_q;
      default:       prdata = '0;
    endcase
  end

  assign key_cfg_o.key_length = key_length_q;
  assign key_cfg_o.key_bytes  = {key_high_q, key_mid_high_q, key_mid_low_q, key_low_q};

endmodule

// ===== design/stl_parser.sv =====
`timescale 1ns / 1ps
// Byte-serial parser state of the symbol table search: header, size,
// entries and the per-image result decision. Depends on stl_pkg.
module stl_parser
  import stl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             last_i,
  input  key_cfg_t         key_cfg_i,
  output logic             emit_o,
  output logic             hit_o,
  output logic [AddrW-1:0] addr_o,
  output stl_status_t      status_o
);

  phase_e           phase_q, phase_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] remain_q, remain_d;
  logic [ByteW-1:0] elen_q, elen_d;
  logic             match_q, match_d;
  logic [ByteW-1:0] hold_q, hold_d;

  logic             decided;
  logic [ByteW-1:0] magic;
  logic [ByteW-1:0] key_byte;
  logic [AddrW-1:0] size_word;
  logic [AddrW-1:0] used;
  logic [AddrW-1:0] remain_left;

  // Key bytes beyond the 32 stored ones compare as zero.
  assign key_byte = (cnt_q[CntW-1:5] == '0)
                  ? key_cfg_i.key_bytes[{cnt_q[4:0], 3'b000} +: ByteW]
                  : '0;

  assign size_word   = {byte_i, remain_q[ByteW-1:0]};
  assign used        = {{(AddrW-ByteW){1'b0}}, elen_q} + AddrW'(3);
  assign remain_left = (remain_q > used) ? (remain_q - used) : '0;

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    magic = MagicS;
      2'd1:    magic = MagicY;
      default: magic = MagicM;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    remain_d = remain_q;
    elen_d   = elen_q;
    match_d  = match_q;
    hold_d   = hold_q;
    decided  = 1'b0;
    hit_o    = 1'b0;
    addr_o   = '0;

    unique case (phase_q)
      PhHeader: begin
        if (byte_i != magic) begin
          decided = 1'b1;
        end else if (cnt_q == CntW'(2)) begin
          phase_d = PhSize;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      PhSize: begin
        if (cnt_q == '0) begin
          remain_d = {{(AddrW-ByteW){1'b0}}, byte_i};
          cnt_d    = CntW'(1);
        end else begin
          remain_d = size_word;
          cnt_d    = '0;
          if (size_word == '0) begin
            decided = 1'b1;
          end else begin
            phase_d = PhLen;
          end
        end
      end
      PhLen: begin
        elen_d  = byte_i;
        match_d = (byte_i == {2'b00, key_cfg_i.key_length})
                  && (key_cfg_i.key_length <= MaxKey);
        cnt_d   = '0;
        phase_d = (byte_i != '0) ? PhName : PhAddr;
      end
      PhName: begin
        if (byte_i != key_byte) begin
          match_d = 1'b0;
        end
        if ((cnt_q + CntW'(1)) >= elen_q) begin
          phase_d = PhAddr;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      PhAddr: begin
        if (cnt_q == '0) begin
          hold_d = byte_i;
          cnt_d  = CntW'(1);
        end else begin
          cnt_d = '0;
          if (match_q) begin
            decided = 1'b1;
            hit_o   = 1'b1;
            addr_o  = {byte_i, hold_q};
          end else begin
            remain_d = remain_left;
            if (remain_left == '0) begin
              decided = 1'b1;
            end else begin
              phase_d = PhLen;
            end
          end
        end
      end
      PhDone: ;
      default: ;
    endcase

    // Every image gives one result: the last byte forces one if none came yet.
    emit_o = decided || (last_i && (phase_q != PhDone));
    if (emit_o) begin
      phase_d = PhDone;
    end
    if (last_i) begin
      phase_d  = PhHeader;
      cnt_d    = '0;
      remain_d = '0;
      elen_d   = '0;
      match_d  = 1'b0;
      hold_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      cnt_q    <= '0;
      remain_q <= '0;
      elen_q   <= '0;
      match_q  <= 1'b0;
      hold_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      remain_q <= remain_d;
      elen_q   <= elen_d;
      match_q  <= match_d;
      hold_q   <= hold_d;
    end
  end

  assign status_o.phase = phase_q;

endmodule

// ===== design/symbol_table_lookup.sv =====
`timescale 1ns / 1ps
// Symbol table lookup: takes a ROM image one byte per request and returns exactly one
// result per image (found flag and 16-bit address, or not found). It accepts one byte
// every cycle; bytes are registered at the input and results at the output. The input
// stalls only when a deciding byte meets a full, stalled output register. The key
// must be written via APB at byte address 8*i when no image is in flight (unchecked).
module symbol_table_lookup
  import stl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ByteW-1:0]  rom_byte_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [AddrW-1:0]  symbol_address_o,
  output logic              found_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  key_cfg_t         key_cfg;
  stl_status_t      status;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             out_valid_q;
  logic [AddrW-1:0] out_addr_q;
  logic             out_found_q;
  logic             emit, hit;
  logic [AddrW-1:0] addr;
  logic             can_take, fire, in_accept;

  stl_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .key_cfg_o (key_cfg)
  );

  stl_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (fire),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .key_cfg_i (key_cfg),
    .emit_o    (emit),
    .hit_o     (hit),
    .addr_o    (addr),
    .status_o  (status)
  );

  // A byte that yields no result moves on even while the output is stalled.
  assign can_take   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && (!emit || can_take);
  assign in_stall_o = in_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= rom_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_addr_q  <= addr;
      out_found_q <= hit;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign symbol_address_o = out_addr_q;
  assign found_o          = out_found_q;

`ifndef NO_ASSERTIONS
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> symbol_address_o == '0)
    else $error("not-found result carries a nonzero address");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_last_q && (status.phase != PhDone) |-> emit)
    else $error("image ended without a result");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_last_q |=> status.phase == PhHeader)
    else $error("parser did not return to the header after the last byte");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !(fire && emit))
    else $error("result register overwritten while stalled");
`endif

endmodule
